@@ hdl/multi_waveform_generator_defines.svh @@
// Assertion macros for the waveform generator checker.
`ifndef MULTI_WAVEFORM_GENERATOR_DEFINES_SVH
`define MULTI_WAVEFORM_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MWG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MWG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwg: next-cycle check failed");

`endif

@@ hdl/mwg_pkg.sv @@
`timescale 1ns / 1ps

package mwg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int STEP_W   = 32;
    localparam int AMP_W    = 15;
    localparam int COUNT_W  = 32;
    localparam int CFG_W    = 32;
    localparam int FRAC_W   = 32;

    localparam int QTR_SIZE = 1 << (SINE_TABLE_BITS - 2);
    localparam int QADDR_W  = SINE_TABLE_BITS - 1;
    localparam int QVAL_W   = 31;
    localparam int SINE_Q   = 30;

    localparam int OP_W     = FRAC_W + 2;
    localparam int PROD_W   = AMP_W + 1 + OP_W;
    localparam int VAL_W    = (SAMPLE_BITS > 19) ? SAMPLE_BITS + 1 : 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS - 1){1'b0}}};
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAWTOOTH = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef enum logic [1:0] {
        REG_WAVE_TYPE    = 2'd0,
        REG_PHASE_STEP   = 2'd1,
        REG_AMPLITUDE    = 2'd2,
        REG_SAMPLE_COUNT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        wave_t              wave_type;
        logic [STEP_W-1:0]  phase_step;
        logic [AMP_W-1:0]   amplitude;
        logic [COUNT_W-1:0] sample_count;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  last;
    } q_entry_t;

    typedef logic [QVAL_W-1:0] qtbl_t [0:QTR_SIZE];

    // Floor quotient by shift and subtract, evaluated at elaboration.
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q30 by Taylor series, evaluated at elaboration.
    function automatic qtbl_t build_qtbl();
        qtbl_t             tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int r = 0; r <= QTR_SIZE; r++)
        begin
            x    = (HALF_PI_Q30 * longint'(r)) >> (SINE_TABLE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x2) >> 30;
                term = udiv64(term, longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< 30))
                sum = 64'sd1 <<< 30;
            tbl[r] = QVAL_W'(sum);
        end
        return tbl;
    endfunction

    localparam qtbl_t QSIN_TBL = build_qtbl();

endpackage

@@ hdl/mwg_fifo.sv @@
`timescale 1ns / 1ps

module mwg_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mwg_pkg::q_entry_t push_data,
    input  logic              pop,
    output mwg_pkg::q_entry_t head,
    output logic              empty,
    output logic              full
);
    import mwg_pkg::*;

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/mwg_front.sv @@
`timescale 1ns / 1ps

module mwg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mwg_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    input  logic              queue_full,
    output logic              push,
    output mwg_pkg::q_entry_t push_data
);
    import mwg_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0]    index_reg, index_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_W-1:0]    index_cur;
    logic                  is_last;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        phase_cur = restart ? '0 : phase_reg;
        index_cur = restart ? '0 : index_reg;
        is_last   = (cfg.sample_count != '0) &&
                    (index_cur == cfg.sample_count - COUNT_W'(1));
        phase_next = phase_reg;
        index_next = index_reg;
        if (push)
        begin
            // wrap to the start of the run on its last sample
            phase_next = is_last ? '0 : phase_cur + PHASE_BITS'(cfg.phase_step);
            index_next = is_last ? '0 : index_cur + COUNT_W'(1);
        end
        push_data.phase = phase_cur;
        push_data.last  = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

endmodule

@@ hdl/mwg_back.sv @@
`timescale 1ns / 1ps

module mwg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mwg_pkg::cfg_t                      cfg,
    input  mwg_pkg::q_entry_t                  head,
    input  logic                               queue_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample,
    output logic                               last
);
    import mwg_pkg::*;

    localparam logic signed [PROD_W-1:0] RND_SINE = PROD_W'(64'd1 << (SINE_Q - 1));
    localparam logic signed [PROD_W-1:0] RND_RAMP = PROD_W'(64'd1 << (FRAC_W - 2));
    localparam logic signed [VAL_W-1:0]  SAT_MAX  = VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [VAL_W-1:0]  SAT_MIN  = VAL_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic [OP_W-1:0]          TWO_TURN = OP_W'(64'd1 << (FRAC_W + 1));

    logic en1, en2, en3;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    logic [QVAL_W-1:0]       s1_q_reg;
    logic                    s1_neg_reg, s1_neg_next;
    logic [FRAC_W-1:0]       s1_frac_reg, s1_frac_next;
    logic signed [VAL_W-1:0] s1_sq_reg, s1_sq_next;
    logic                    s1_last_reg;

    logic signed [PROD_W-1:0] s2_prod_reg, s2_prod_next;
    logic signed [VAL_W-1:0]  s2_sq_reg;
    logic                     s2_last_reg;

    logic signed [SAMPLE_BITS-1:0] s3_sample_reg, s3_sample_next;
    logic                          s3_last_reg;

    logic [SINE_TABLE_BITS-1:0]      tbl_idx;
    logic [SINE_TABLE_BITS-3:0]      tbl_r;
    logic [QADDR_W-1:0]              q_addr;
    logic [PHASE_BITS+FRAC_W-1:0]    frac_wide;
    logic signed [VAL_W-1:0]         amp_v;
    logic signed [AMP_W:0]           amp_s;
    logic signed [OP_W-1:0]          op;
    logic [OP_W-1:0]                 tri_u;
    logic [OP_W-1:0]                 two_f;
    logic signed [PROD_W-1:0]        rnd_sum;
    logic signed [PROD_W-1:0]        rnd_shift;
    logic signed [VAL_W-1:0]         val;

    assign en3 = !s3_valid_reg || out_ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pop = !queue_empty && en1;

    assign s1_valid_next = en1 ? pop          : s1_valid_reg;
    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;

    assign amp_s = $signed({1'b0, cfg.amplitude});
    assign amp_v = VAL_W'(amp_s);

    // stage 1: table address, phase fraction, square level
    always_comb
    begin
        tbl_idx      = head.phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        tbl_r        = tbl_idx[SINE_TABLE_BITS-3:0];
        q_addr       = tbl_idx[SINE_TABLE_BITS-2] ?
                       QADDR_W'(QTR_SIZE) - QADDR_W'(tbl_r) : QADDR_W'(tbl_r);
        s1_neg_next  = tbl_idx[SINE_TABLE_BITS-1];
        frac_wide    = {head.phase, {FRAC_W{1'b0}}} >> PHASE_BITS;
        s1_frac_next = frac_wide[FRAC_W-1:0];
        if (head.phase == '0 || head.phase == HALF_PHASE)
            s1_sq_next = '0;
        else if (head.phase < HALF_PHASE)
            s1_sq_next = amp_v;
        else
            s1_sq_next = -amp_v;
    end

    // stage 2: one multiply by the amplitude
    always_comb
    begin
        two_f = {1'b0, s1_frac_reg, 1'b0};
        tri_u = s1_frac_reg[FRAC_W-1] ? TWO_TURN - two_f : two_f;
        case (cfg.wave_type)
            WAVE_SINE:
            begin
                op = $signed({{(OP_W - QVAL_W){1'b0}}, s1_q_reg});
                if (s1_neg_reg)
                    op = -op;
            end
            WAVE_SAWTOOTH: op = $signed({2'b00, s1_frac_reg});
            WAVE_TRIANGLE: op = $signed(tri_u);
            default:       op = '0;
        endcase
        s2_prod_next = amp_s * op;
    end

    // stage 3: round, offset, clamp
    always_comb
    begin
        rnd_sum   = '0;
        rnd_shift = '0;
        case (cfg.wave_type)
            WAVE_SINE:
            begin
                rnd_sum   = s2_prod_reg + RND_SINE;
                rnd_shift = rnd_sum >>> SINE_Q;
                val       = VAL_W'(rnd_shift);
            end
            WAVE_SAWTOOTH, WAVE_TRIANGLE:
            begin
                rnd_sum   = s2_prod_reg + RND_RAMP;
                rnd_shift = rnd_sum >>> (FRAC_W - 1);
                val       = VAL_W'(rnd_shift) - amp_v;
            end
            default: val = s2_sq_reg;
        endcase
        if (val > SAT_MAX)
            val = SAT_MAX;
        else if (val < SAT_MIN)
            val = SAT_MIN;
        s3_sample_next = val[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_q_reg    <= QSIN_TBL[q_addr];
            s1_neg_reg  <= s1_neg_next;
            s1_frac_reg <= s1_frac_next;
            s1_sq_reg   <= s1_sq_next;
            s1_last_reg <= head.last;
        end
        if (en2)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_sq_reg   <= s1_sq_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (en3)
        begin
            s3_sample_reg <= s3_sample_next;
            s3_last_reg   <= s2_last_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign sample    = s3_sample_reg;
    assign last      = s3_last_reg;

endmodule

@@ hdl/multi_waveform_generator.sv @@
`timescale 1ns / 1ps

// Four-wave numerically controlled oscillator (sine, sawtooth, square, triangle).
// Each accepted request is one tick: it yields one signed sample and then steps
// the 32-bit phase by phase_step, or wraps it to zero on the last sample of a run.
// Sustained rate is one request per clock while the queue is not full, set by the
// phase add and run-end compare in the front end; a request passes through a
// four-entry queue and a three-stage shaper (table read, amplitude multiply,
// rounding and clamp) before it appears on the output. Output stalls back up
// through the queue before the input side stalls. Write the configuration
// registers only while no request is in flight.
module multi_waveform_generator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [mwg_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   last
);
    import mwg_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    q_entry_t push_data;
    q_entry_t head;
    logic     push;
    logic     pop;
    logic     queue_empty;
    logic     queue_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WAVE_TYPE:    cfg_next.wave_type    = wave_t'(cfg_data[1:0]);
                REG_PHASE_STEP:   cfg_next.phase_step   = cfg_data[STEP_W-1:0];
                REG_AMPLITUDE:    cfg_next.amplitude    = cfg_data[AMP_W-1:0];
                REG_SAMPLE_COUNT: cfg_next.sample_count = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    mwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    mwg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    mwg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .last        (last)
    );

endmodule

@@ hdl/mwg_checker.sv @@
`timescale 1ns / 1ps
`include "multi_waveform_generator_defines.svh"

module mwg_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample,
    input logic                                   last
);
    import mwg_pkg::*;

    logic [3:0] pend_reg, pend_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
            pend_next = pend_reg + 1'b1;
        else if (out_fire && !in_fire)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `MWG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(last))
    `MWG_ASSERT_IMP(a_no_phantom, out_valid, pend_reg != 4'd0)
    `MWG_ASSERT_IMP(a_ready_when_empty, pend_reg == 4'd0, in_ready)
    `MWG_ASSERT_NXT(a_drain_idle, out_fire && !in_fire && pend_reg == 4'd1, !out_valid)

endmodule

bind multi_waveform_generator mwg_checker u_mwg_checker (.*);

@@ dv/multi_waveform_generator_tb.sv @@
`timescale 1ns / 1ps

module multi_waveform_generator_tb;

    import mwg_pkg::*;

    localparam int IDLE_LIMIT       = 2000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int RECV_HOLD_CYCLES = 200;
    localparam int RANDOM_TICKS     = 1500;
    localparam int MAX_PRINTED      = 40;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } sample_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          restart   = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    // oscillator copy kept by the testbench
    int                    sine_q30 [0:(1 << SINE_TABLE_BITS) - 1];
    wave_t                 wave_sel  = WAVE_SINE;
    logic [STEP_W-1:0]     step_word = '0;
    logic [AMP_W-1:0]      amp       = '0;
    logic [COUNT_W-1:0]    run_len   = '0;
    logic [PHASE_BITS-1:0] osc_phase = '0;
    logic [31:0]           osc_index = '0;

    bit             pending_restarts [$];
    sample_result_t expected_samples [$];

    int ticks_queued    = 0;
    int ticks_accepted  = 0;
    int samples_seen    = 0;
    int fail_count      = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit tick_hold       = 1'b0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;

    multi_waveform_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .last      (last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINTED)
            $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(logic [PHASE_BITS-1:0] ph);
        longint          v;
        longint unsigned t;
        longint unsigned u;
        case (wave_sel)
            WAVE_SINE:
            begin
                v = longint'(amp) * longint'(sine_q30[ph[PHASE_BITS-1 -: SINE_TABLE_BITS]])
                    + (64'sd1 <<< 29);
                v = v >>> 30;
            end
            WAVE_SAWTOOTH:
            begin
                t = 64'd2 * 64'(amp) * 64'(ph) + 64'h8000_0000;
                v = longint'(t >> 32) - longint'(amp);
            end
            WAVE_SQUARE:
            begin
                if (ph == '0 || ph == HALF_PHASE)
                    v = 0;
                else if (!ph[PHASE_BITS-1])
                    v = longint'(amp);
                else
                    v = -longint'(amp);
            end
            default:
            begin
                u = ph[PHASE_BITS-1] ? 64'd2 * (64'h1_0000_0000 - 64'(ph)) : 64'd2 * 64'(ph);
                t = 64'd2 * 64'(amp) * u + 64'h8000_0000;
                v = longint'(t >> 32) - longint'(amp);
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_result_t predict_tick(logic rs);
        sample_result_t r;
        if (rs)
        begin
            osc_phase = '0;
            osc_index = '0;
        end
        r.sample = shape_sample(osc_phase);
        r.last   = (run_len != '0) && (osc_index == run_len - 1);
        if (r.last)
        begin
            osc_phase = '0;
            osc_index = '0;
        end
        else
        begin
            osc_phase = osc_phase + step_word;
            osc_index = osc_index + 1;
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_restarts.size() != 0 && !tick_hold &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                restart  <= pending_restarts.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver back-pressure, with an occasional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = RECV_HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                samples_seen++;
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected sample %0d last %0b", sample, last));
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.sample)
                        report_mismatch($sformatf("sample %0d, want %0d (result %0d)",
                                                  sample, want.sample, samples_seen));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (result %0d)",
                                                  last, want.last, samples_seen));
                end
            end
            if (in_valid && in_ready)
            begin
                ticks_accepted++;
                expected_samples.push_back(predict_tick(restart));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_WAVE_TYPE:    wave_sel  = wave_t'(data[1:0]);
            REG_PHASE_STEP:   step_word = data[STEP_W-1:0];
            REG_AMPLITUDE:    amp       = data[AMP_W-1:0];
            REG_SAMPLE_COUNT: run_len   = data[COUNT_W-1:0];
            default:          ;
        endcase
    endtask

    // upper data bits beyond the wave type and amplitude fields are random and must be dropped
    task automatic program_osc(wave_t w, logic [31:0] step, logic [AMP_W-1:0] a,
                               logic [31:0] n);
        write_reg(REG_WAVE_TYPE, ($urandom & 32'hFFFF_FFFC) | 32'(w));
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_AMPLITUDE, ($urandom & 32'hFFFF_8000) | 32'(a));
        write_reg(REG_SAMPLE_COUNT, n);
    endtask

    task automatic queue_ticks(int n, int restart_pct);
        for (int i = 0; i < n; i++)
        begin
            pending_restarts.push_back($urandom_range(99) < restart_pct);
            ticks_queued++;
        end
    endtask

    task automatic wait_drained();
        wait (ticks_accepted == ticks_queued && samples_seen == ticks_queued);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              rr;
        int              phase_no;
        int              random_sent;
        int              n;
        int              rpct;
        int              base;
        logic [31:0]     step;
        logic [31:0]     count;
        logic [AMP_W-1:0] a;

        // quarter-wave Taylor series, mirrored into a full-turn table
        for (int k = 0; k < (1 << SINE_TABLE_BITS); k++)
        begin
            rr = k & (QTR_SIZE - 1);
            if (((k >> (SINE_TABLE_BITS - 2)) & 1) == 1)
                rr = QTR_SIZE - rr;
            x    = (64'd1686629713 * 64'(rr)) >> (SINE_TABLE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int m = 1; m <= 7; m++)
            begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * m) * (2 * m + 1));
                if (m % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< 30))
                sum = 64'sd1 <<< 30;
            sine_q30[k] = (((k >> (SINE_TABLE_BITS - 1)) & 1) == 1) ? -int'(sum) : int'(sum);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        queue_ticks(3, 0);
        wait_drained();
        program_osc(WAVE_SINE, 32'h4000_0000, 15'h7FFF, 32'd0);
        queue_ticks(5, 0);
        wait_drained();
        program_osc(WAVE_SAWTOOTH, 32'h8000_0000, 15'h7FFF, 32'd0);
        queue_ticks(3, 0);
        wait_drained();
        program_osc(WAVE_SQUARE, 32'h8000_0000, 15'd1, 32'd0);
        queue_ticks(3, 0);
        wait_drained();
        program_osc(WAVE_TRIANGLE, 32'h4000_0000, 15'h7FFF, 32'd4);
        queue_ticks(1, 100);
        queue_ticks(5, 0);
        wait_drained();
        program_osc(WAVE_SAWTOOTH, 32'hFFFF_FFFF, 15'h7FFF, 32'd1);
        queue_ticks(2, 0);
        wait_drained();
        program_osc(WAVE_SINE, 32'h0123_4567, 15'h7FFF, 32'hFFFF_FFFF);
        queue_ticks(2, 100);
        wait_drained();

        // random
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_TICKS)
        begin
            case (phase_no % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
            endcase

            case ($urandom_range(5))
                0:       step = $urandom;
                1:       step = $urandom_range(1, 1 << 20);
                2:       step = 32'h1 << $urandom_range(31);
                3:       step = 32'hFFFF_FFFF - $urandom_range(1000);
                4:       step = 32'h4000_0000 * $urandom_range(3);
                default: step = $urandom;
            endcase
            case ($urandom_range(3))
                0:       a = 15'h7FFF;
                1:       a = '0;
                default: a = $urandom_range(32767);
            endcase
            case ($urandom_range(6))
                0:       count = '0;
                1:       count = $urandom_range(1, 40);
                2:       count = osc_index + $urandom_range(1, 30);
                3:       count = $urandom;
                4:       count = 32'hFFFF_FFFF;
                5:       count = osc_index;
                default: count = $urandom_range(1, 8);
            endcase
            program_osc(wave_t'($urandom_range(3)), step, a, count);

            n = $urandom_range(30, 70);
            case ($urandom_range(2))
                0:       rpct = 0;
                1:       rpct = 3;
                default: rpct = 20;
            endcase

            if (phase_no == 2)
            begin
                sender_idle_pct = 0;
                hold_requests++;
            end
            base = ticks_accepted;
            queue_ticks(n, rpct);
            if (phase_no == 5)
            begin
                wait (ticks_accepted >= base + 10);
                tick_hold = 1'b1;
                wait (samples_seen == ticks_accepted && !in_valid);
                repeat (SETTLE_CYCLES) @(posedge clk);
                tick_hold = 1'b0;
            end
            wait_drained();
            random_sent += n;
            phase_no++;
        end

        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never produced", expected_samples.size()));
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ multi_waveform_generator.f @@
+incdir+hdl
hdl/mwg_pkg.sv
hdl/mwg_fifo.sv
hdl/mwg_front.sv
hdl/mwg_back.sv
hdl/multi_waveform_generator.sv
hdl/mwg_checker.sv
dv/multi_waveform_generator_tb.sv
